// ----- sv/discrete_gittins_index_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the discrete Gittins index unit
// Clocked property checks that disappear when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DISCRETE_GITTINS_INDEX_UNIT_ASSERT_SVH
`define DISCRETE_GITTINS_INDEX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DGI_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define DGI_ASSERT(lbl, prop, msg)
`define DGI_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- sv/dgi_pkg.sv -----
// ----------------------------------------------------------------------------
// dgi_pkg
// Shared widths, codes and interface types of the discrete Gittins index unit.
// ----------------------------------------------------------------------------
package dgi_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned WGT_W       = 16;
  localparam int unsigned WSUM_W      = 20;
  localparam int unsigned PROD_W      = 52;
  localparam int unsigned POS_W       = 53;
  localparam int unsigned DVD_W       = 77;
  localparam int unsigned DSR_W       = 52;
  localparam int unsigned REM_W       = 53;
  localparam int unsigned QUO_W       = 48;
  localparam int unsigned DCNT_W      = 7;

  localparam logic [QUO_W-1:0]  IDX_MAX    = '1;
  localparam logic [DCNT_W-1:0] TERM_BITS  = 7'd48;
  localparam logic [DCNT_W-1:0] PLAIN_BITS = 7'd53;
  localparam logic [DCNT_W-1:0] SLOW_BITS  = 7'd77;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TOO_OLD = 2'd1,
    STAT_LOADED  = 2'd2
  } status_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic {
    CFG_ENTRIES  = 1'b0,
    CFG_SLOWDOWN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
    logic [DCNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             overflow;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/dgi_table.sv -----
// ----------------------------------------------------------------------------
// dgi_table
// Size and weight storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dgi_table (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [dgi_pkg::ADDR_W-1:0]  waddr_i,
  input  logic [dgi_pkg::SIZE_W-1:0]  wsize_i,
  input  logic [dgi_pkg::WGT_W-1:0]   wweight_i,
  input  logic [dgi_pkg::ADDR_W-1:0]  raddr_i,
  output logic [dgi_pkg::SIZE_W-1:0]  rsize_o,
  output logic [dgi_pkg::WGT_W-1:0]   rweight_o
);

  logic [dgi_pkg::SIZE_W-1:0] size_mem [dgi_pkg::MAX_ENTRIES];
  logic [dgi_pkg::WGT_W-1:0]  wgt_mem  [dgi_pkg::MAX_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      size_mem[waddr_i] <= wsize_i;
      wgt_mem[waddr_i]  <= wweight_i;
    end
    rsize_o   <= size_mem[raddr_i];
    rweight_o <= wgt_mem[raddr_i];
  end

endmodule

// ----- sv/dgi_div.sv -----
// ----------------------------------------------------------------------------
// dgi_div
// Restoring divider, one quotient bit per cycle from the top of the dividend.
// ----------------------------------------------------------------------------
module dgi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dgi_pkg::div_req_t req_i,
  output dgi_pkg::div_rsp_t rsp_o
);

  logic [dgi_pkg::DVD_W-1:0]  dvd_q, dvd_d;
  logic [dgi_pkg::DSR_W-1:0]  dsr_q, dsr_d;
  logic [dgi_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [dgi_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic                       ovf_q, ovf_d;
  logic [dgi_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [dgi_pkg::REM_W:0]    trial;
  logic [dgi_pkg::REM_W:0]    diff;
  logic                       fits;

  assign trial = {rem_q, dvd_q[dgi_pkg::DVD_W-1]};
  assign diff  = trial - {2'b00, dsr_q};
  assign fits  = trial >= {2'b00, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[dgi_pkg::REM_W-1:0] : trial[dgi_pkg::REM_W-1:0];
      dvd_d = {dvd_q[dgi_pkg::DVD_W-2:0], 1'b0};
      // Any bit pushed out of the quotient register means saturation.
      ovf_d = ovf_q | quo_q[dgi_pkg::QUO_W-1];
      quo_d = {quo_q[dgi_pkg::QUO_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.overflow = ovf_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- sv/discrete_gittins_index_unit.sv -----
// Load request: the table is written and the status goes to the result register. Query:
// a scan of the table entries, then per cutoff the states S_LPA to S_NEXT plus one
// bit-serial division of 53 steps (plain) or 48 + 77 steps (slowdown) on the single
// shared divider. One request at a time.
// Reset clears control state and sets entries_in_use to 1, slowdown_mode to 0;
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
// discrete_gittins_index_unit
// Gittins index over a discrete size table, computed with one shared
// multiplier and one shared divider under a one-hot sequencer.
// ----------------------------------------------------------------------------
`include "discrete_gittins_index_unit_assert.svh"

module discrete_gittins_index_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [3:0]  entry_slot_i,
  input  logic [31:0] entry_size_i,
  input  logic [15:0] entry_weight_i,
  input  logic [31:0] job_age_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] index_value_o,
  output logic [31:0] time_to_change_o,
  output logic [1:0]  status_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_SCANA = 15'h0002,
    S_SCANB = 15'h0004,
    S_MSUB  = 15'h0008,
    S_SUBW  = 15'h0010,
    S_LPA   = 15'h0020,
    S_LPB   = 15'h0040,
    S_POS   = 15'h0080,
    S_LOW   = 15'h0100,
    S_ACC   = 15'h0200,
    S_TERM  = 15'h0400,
    S_RATIO = 15'h0800,
    S_RWAIT = 15'h1000,
    S_NEXT  = 15'h2000,
    S_DONE  = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic [dgi_pkg::CNT_W-1:0]  entries_q;
  logic                       slow_q;
  logic [dgi_pkg::CNT_W-1:0]  n_q, idx_q, k_q;
  logic                       found_q;
  logic [31:0]                age_q, sizek_q, v_q;
  logic [15:0]                w_q;
  logic [dgi_pkg::WSUM_W-1:0] wrem_q, wbelow_q;
  logic [dgi_pkg::PROD_W-1:0] sub_q, lower_q, mul_q, prod;
  logic [dgi_pkg::POS_W-1:0]  pos_q, num_q;
  logic [dgi_pkg::DSR_W-1:0]  dcum_q;
  logic [dgi_pkg::QUO_W-1:0]  best_q, ratio;
  logic [47:0]                res_idx_q;
  logic [31:0]                res_ttc_q;
  dgi_pkg::status_e           res_st_q;
  logic                       out_valid_q;
  logic [47:0]                out_idx_q;
  logic [31:0]                out_ttc_q;
  dgi_pkg::status_e           out_st_q;
  logic [31:0]                mul_a;
  logic [dgi_pkg::WSUM_W-1:0] mul_b;
  logic [31:0]                rsize, dv;
  logic [15:0]                rweight;
  logic                       in_acc, out_acc, last, hit;
  dgi_pkg::div_req_t          div_req;
  dgi_pkg::div_rsp_t          div_rsp;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign last = (idx_q + 1'b1) == n_q;
  assign hit  = rsize > age_q;
  assign dv   = (v_q == '0) ? 32'd1 : v_q;
  assign ratio = div_rsp.overflow ? dgi_pkg::IDX_MAX : div_rsp.quotient;

  dgi_table u_table (
    .clk_i     (clk_i),
    .we_i      (in_acc && (opcode_i == dgi_pkg::OP_LOAD)),
    .waddr_i   (entry_slot_i),
    .wsize_i   (entry_size_i),
    .wweight_i (entry_weight_i),
    .raddr_i   (idx_q[dgi_pkg::ADDR_W-1:0]),
    .rsize_o   (rsize),
    .rweight_o (rweight)
  );

  dgi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared multiplier: operands chosen by state, product registered.
  always_comb begin
    mul_a = v_q;
    mul_b = wrem_q - wbelow_q;
    case (state_q)
      S_MSUB: begin
        mul_a = age_q;
        mul_b = wrem_q;
      end
      S_LOW: begin
        mul_a = v_q;
        mul_b = {4'b0, w_q};
      end
      default: begin
        mul_a = v_q;
        mul_b = wrem_q - wbelow_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    mul_q <= prod;
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {num_q, 24'b0};
    div_req.divisor  = dcum_q;
    div_req.steps    = slow_q ? dgi_pkg::SLOW_BITS : dgi_pkg::PLAIN_BITS;
    if (state_q == S_ACC && slow_q) begin
      div_req.start    = 1'b1;
      div_req.dividend = {w_q, 61'b0};
      div_req.divisor  = {20'b0, dv};
      div_req.steps    = dgi_pkg::TERM_BITS;
    end else if (state_q == S_RATIO && dcum_q != '0) begin
      div_req.start = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (opcode_i == dgi_pkg::OP_LOAD) begin
            state_d = S_DONE;
          end else if (entries_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCANA;
          end
        end
      end
      S_SCANA: state_d = S_SCANB;
      S_SCANB: begin
        if (!last) begin
          state_d = S_SCANA;
        end else if (found_q || hit) begin
          state_d = S_MSUB;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MSUB:  state_d = S_SUBW;
      S_SUBW:  state_d = S_LPA;
      S_LPA:   state_d = S_LPB;
      S_LPB:   state_d = S_POS;
      S_POS:   state_d = S_LOW;
      S_LOW:   state_d = S_ACC;
      S_ACC:   state_d = slow_q ? S_TERM : S_RATIO;
      S_TERM: begin
        if (div_rsp.done) begin
          state_d = S_RATIO;
        end
      end
      S_RATIO: state_d = (dcum_q != '0) ? S_RWAIT : S_NEXT;
      S_RWAIT: begin
        if (div_rsp.done) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT:  state_d = last ? S_DONE : S_LPA;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= 5'd1;
      slow_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dgi_pkg::CFG_ENTRIES:  entries_q <= cfg_data_i;
          dgi_pkg::CFG_SLOWDOWN: slow_q    <= cfg_data_i[0];
          default:               slow_q    <= slow_q;
        endcase
      end
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        S_SCANB: begin
          if (!found_q && hit) begin
            found_q <= 1'b1;
          end
          if (!last) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_SUBW: idx_q <= k_q;
        S_NEXT: idx_q <= idx_q + 1'b1;
        default: idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        age_q     <= job_age_i;
        wrem_q    <= '0;
        n_q       <= (entries_q > 5'(dgi_pkg::MAX_ENTRIES)) ?
                     5'(dgi_pkg::MAX_ENTRIES) : entries_q;
        res_idx_q <= '0;
        res_ttc_q <= '0;
        res_st_q  <= (opcode_i == dgi_pkg::OP_LOAD) ?
                     dgi_pkg::STAT_LOADED : dgi_pkg::STAT_TOO_OLD;
      end
      S_SCANB: begin
        if (!found_q && hit) begin
          k_q     <= idx_q;
          sizek_q <= rsize;
        end
        if (found_q || hit) begin
          wrem_q <= wrem_q + {4'b0, rweight};
        end
      end
      S_SUBW: begin
        sub_q    <= mul_q;
        wbelow_q <= '0;
        lower_q  <= '0;
        dcum_q   <= '0;
        best_q   <= dgi_pkg::IDX_MAX;
      end
      S_LPB: begin
        v_q <= rsize;
        w_q <= rweight;
      end
      S_LOW: pos_q <= {1'b0, mul_q} + {1'b0, lower_q};
      S_ACC: begin
        // Numerators below zero only arise from an unsorted table.
        num_q    <= (pos_q > {1'b0, sub_q}) ? pos_q - {1'b0, sub_q} : '0;
        lower_q  <= lower_q + mul_q;
        wbelow_q <= wbelow_q + {4'b0, w_q};
        if (!slow_q) begin
          dcum_q <= dcum_q + {36'b0, w_q};
        end
      end
      S_TERM: begin
        if (div_rsp.done) begin
          dcum_q <= dcum_q + {4'b0, div_rsp.quotient};
        end
      end
      S_RWAIT: begin
        if (div_rsp.done && ratio < best_q) begin
          best_q <= ratio;
        end
      end
      S_NEXT: begin
        if (last) begin
          res_idx_q <= best_q;
          res_ttc_q <= sizek_q - age_q;
          res_st_q  <= dgi_pkg::STAT_OK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_idx_q <= res_idx_q;
          out_ttc_q <= res_ttc_q;
          out_st_q  <= res_st_q;
        end
      end
      default: begin
        sub_q <= sub_q;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign index_value_o    = out_idx_q;
  assign time_to_change_o = out_ttc_q;
  assign status_o         = out_st_q;

  `DGI_ASSERT(a_busy_after_req, in_valid_i && !in_stall_o |=> in_stall_o, "request not held off")
  `DGI_ASSERT_NEVER(a_div_overlap, div_req.start && div_rsp.busy, "divider restarted while busy")
  `DGI_ASSERT(a_out_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE), "stray result")
  `DGI_ASSERT_NEVER(a_div_idle_wait, (state_q == S_RWAIT || state_q == S_TERM) && !div_rsp.busy && !div_rsp.done, "waiting on idle divider")

endmodule
